// File: src/assert_macros.svh
// Assertion macros for the checker file prd_checker.sv.
// Depends on signals clk and rst being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define PRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs during reset
`define PRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/prd_pkg.sv
// Package for the PLL rate decoder: field layout, widths, constants, register indexes.
// No dependencies.
package prd_pkg;

  localparam int WordW    = 32;
  localparam int NumW     = 10;
  localparam int MultW    = 4;
  localparam int DenW     = 10;
  localparam int PreW     = 4;

  localparam int NumLo    = 0;
  localparam int MultLo   = 10;
  localparam int DenLo    = 16;
  localparam int PreLo    = 26;

  localparam int PreDivW  = PreW + 1;
  localparam int DenDivW  = DenW + 1;
  localparam int ProdW    = WordW + NumW;

  localparam int StepsDefault = 4;
  localparam int CfgIndexW    = 1;

  localparam logic [MultW-1:0] MultMin = MultW'(5);
  localparam logic [NumW-1:0]  NumSign = NumW'(10'h200);
  localparam logic [NumW:0]    NumSpan = (NumW + 1)'(11'h400);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_REFERENCE_RATE       = 1'b0,
    CFG_SIGNED_FRACTION_MODE = 1'b1
  } cfg_index_t;

endpackage

// File: src/pll_rate_decoder_unit.sv
// PLL rate decoder top level: pipelined predivision, multiply and fraction division.
// Depends on prd_pkg.
//
//   channel  | dir | payload (low bit up)
//   s_axis   | in  | tdata: pll_setting[31:0]
//   m_axis   | out | tdata: output_rate[31:0]
//   cfg      | in  | cfg_index: 0 reference_rate, 1 signed_fraction_mode
//
// One item per cycle while m_axis_tready is high; the pipeline depth is set by
// the two restoring dividers that retire STEPS quotient bits per stage. Reset
// clears all valid bits and loads the register defaults. A stall at m_axis
// holds only as many stages as are full; bubbles close up.
module pll_rate_decoder_unit #(
  parameter int STEPS = prd_pkg::StepsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [prd_pkg::WordW-1:0]        s_axis_tdata,   // pll_setting[31:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [prd_pkg::WordW-1:0]        m_axis_tdata,   // output_rate[31:0]
  input  logic                             cfg_wen,
  input  logic [prd_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [prd_pkg::WordW-1:0]        cfg_data
);
  import prd_pkg::*;

  localparam int NA  = (WordW + STEPS - 1) / STEPS;
  localparam int WA  = NA * STEPS;
  localparam int NC  = (ProdW + STEPS - 1) / STEPS;
  localparam int WC  = NC * STEPS;
  localparam int NST = NA + NC + 3;
  localparam int IB  = NA + 1;

  typedef struct packed {
    logic [MultW-1:0]   mult;
    logic [NumW-1:0]    mag;
    logic               neg;
    logic [DenDivW-1:0] den;
  } side_a_t;

  typedef struct packed {
    logic [WordW-1:0]   bm;
    logic               neg;
    logic [DenDivW-1:0] den;
  } side_c_t;

  logic [WordW-1:0] reference_rate;
  logic             signed_fraction_mode;

  logic [NST-1:0] vld;
  logic [NST:0]   adv;

  logic [WA-1:0]      a_qr   [0:NA];
  logic [PreDivW-1:0] a_rem  [0:NA];
  logic [PreDivW-1:0] a_dvs  [0:NA];
  side_a_t            a_side [0:NA];
  logic [WA-1:0]      a_qr_next  [1:NA];
  logic [PreDivW-1:0] a_rem_next [1:NA];

  logic [WC-1:0]      c_qr   [0:NC];
  logic [DenDivW-1:0] c_rem  [0:NC];
  side_c_t            c_side [0:NC];
  logic [WC-1:0]      c_qr_next  [1:NC];
  logic [DenDivW-1:0] c_rem_next [1:NC];

  logic [WordW-1:0] result;

  logic [NumW-1:0]    in_numer;
  logic [MultW-1:0]   in_mult_raw;
  logic [DenW-1:0]    in_den_raw;
  logic [PreW-1:0]    in_pre_raw;
  logic               in_neg;
  logic [NumW:0]      in_span_diff;
  logic [WordW-1:0]   in_dbl;

  logic [WordW-1:0]       base;
  logic [ProdW-1:0]       prod_full;
  logic [WordW+MultW-1:0] bm_full;
  logic [WordW-1:0]       frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_rate       <= '0;
      signed_fraction_mode <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_index_t'(cfg_index))
        CFG_REFERENCE_RATE:       reference_rate       <= cfg_data;
        CFG_SIGNED_FRACTION_MODE: signed_fraction_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    adv[NST] = m_axis_tready;
    for (int i = 0; i < NST; i++) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Unpack the setting word
  assign in_numer     = s_axis_tdata[NumLo +: NumW];
  assign in_mult_raw  = s_axis_tdata[MultLo +: MultW];
  assign in_den_raw   = s_axis_tdata[DenLo +: DenW];
  assign in_pre_raw   = s_axis_tdata[PreLo +: PreW];
  assign in_neg       = signed_fraction_mode && (in_numer >= NumSign);
  assign in_span_diff = NumSpan - {1'b0, in_numer};
  assign in_dbl       = {reference_rate[WordW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_qr[0]        <= WA'(in_dbl);
      a_rem[0]       <= '0;
      a_dvs[0]       <= {1'b0, in_pre_raw} + PreDivW'(1);
      a_side[0].mult <= (in_mult_raw < MultMin) ? MultMin : in_mult_raw;
      a_side[0].mag  <= in_neg ? in_span_diff[NumW-1:0] : in_numer;
      a_side[0].neg  <= in_neg;
      a_side[0].den  <= {1'b0, in_den_raw} + DenDivW'(1);
    end
  end

  // Base divider: doubled reference over predivider + 1
  for (genvar j = 1; j <= NA; j++) begin : g_div_a
    always_comb begin
      logic [WA-1:0]      q;
      logic [PreDivW-1:0] r;
      logic [PreDivW:0]   t;
      q = a_qr[j-1];
      r = a_rem[j-1];
      t = '0;
      for (int s = 0; s < STEPS; s++) begin
        t = {r, q[WA-1]};
        q = {q[WA-2:0], 1'b0};
        if (t >= {1'b0, a_dvs[j-1]}) begin
          t    = t - {1'b0, a_dvs[j-1]};
          q[0] = 1'b1;
        end
        r = t[PreDivW-1:0];
      end
      a_qr_next[j]  = q;
      a_rem_next[j] = r;
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        a_qr[j]   <= a_qr_next[j];
        a_rem[j]  <= a_rem_next[j];
        a_dvs[j]  <= a_dvs[j-1];
        a_side[j] <= a_side[j-1];
      end
    end
  end

  // Multiply stage
  assign base      = a_qr[NA][WordW-1:0];
  assign prod_full = base * a_side[NA].mag;
  assign bm_full   = base * a_side[NA].mult;

  always_ff @(posedge clk) begin
    if (adv[IB]) begin
      c_qr[0]       <= WC'(prod_full);
      c_rem[0]      <= '0;
      c_side[0].bm  <= bm_full[WordW-1:0];
      c_side[0].neg <= a_side[NA].neg;
      c_side[0].den <= a_side[NA].den;
    end
  end

  // Fraction divider: product over denominator + 1
  for (genvar j = 1; j <= NC; j++) begin : g_div_c
    always_comb begin
      logic [WC-1:0]      q;
      logic [DenDivW-1:0] r;
      logic [DenDivW:0]   t;
      q = c_qr[j-1];
      r = c_rem[j-1];
      t = '0;
      for (int s = 0; s < STEPS; s++) begin
        t = {r, q[WC-1]};
        q = {q[WC-2:0], 1'b0};
        if (t >= {1'b0, c_side[j-1].den}) begin
          t    = t - {1'b0, c_side[j-1].den};
          q[0] = 1'b1;
        end
        r = t[DenDivW-1:0];
      end
      c_qr_next[j]  = q;
      c_rem_next[j] = r;
    end

    always_ff @(posedge clk) begin
      if (adv[IB+j]) begin
        c_qr[j]   <= c_qr_next[j];
        c_rem[j]  <= c_rem_next[j];
        c_side[j] <= c_side[j-1];
      end
    end
  end

  // Combine and wrap
  assign frac = c_qr[NC][WordW-1:0];

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      result <= c_side[NC].neg ? (c_side[NC].bm - frac) : (c_side[NC].bm + frac);
    end
  end

endmodule

// File: src/prd_checker.sv
// Port-level checker for pll_rate_decoder_unit and its bind statement.
// Depends on prd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prd_checker #(
  parameter int STEPS = prd_pkg::StepsDefault
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [prd_pkg::WordW-1:0] m_axis_tdata    // output_rate[31:0]
);
  import prd_pkg::*;

  localparam int Depth = (WordW + STEPS - 1) / STEPS + (ProdW + STEPS - 1) / STEPS + 3;
  localparam int CntW  = $clog2(Depth + 2);

  logic [CntW-1:0] in_flight;
  logic            in_take;
  logic            out_take;
  logic            out_wait;
  logic            out_idle;

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign out_wait = m_axis_tvalid && !m_axis_tready;
  assign out_idle = !m_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CntW'(in_take) - CntW'(out_take);
    end
  end

  `PRD_ASSERT(a_out_hold, out_wait |=> m_axis_tvalid && $stable(m_axis_tdata), "held item changed")
  `PRD_ASSERT(a_out_has_item, m_axis_tvalid |-> in_flight != '0, "output with nothing in flight")
  `PRD_ASSERT(a_depth_bound, in_flight <= CntW'(Depth), "more items in flight than stages")
  `PRD_ASSERT(a_ready_follows, m_axis_tready |-> s_axis_tready, "input stalled while output ready")
  `PRD_ASSERT_ALWAYS(a_reset_empty, $past(rst) && !rst |-> out_idle, "pipeline not empty after reset")

endmodule

bind pll_rate_decoder_unit prd_checker #(.STEPS(STEPS)) u_prd_checker (.*);

// File: dv/pll_rate_decoder_unit_tb.sv
// Self-checking testbench for pll_rate_decoder_unit: random and directed setting words
// against a scoreboard that predicts the output rate. Depends on prd_pkg and the unit.
import prd_pkg::*;

class rate_scoreboard;
  logic [WordW-1:0] ref_hz;
  bit               signed_num;
  logic [WordW-1:0] rate_q[$];
  int               errors;

  function new();
    ref_hz     = '0;
    signed_num = 1'b1;
    errors     = 0;
  endfunction

  function void set_config(logic [WordW-1:0] hz, bit mode, bit with_mode);
    ref_hz = hz;
    if (with_mode) begin
      signed_num = mode;
    end
  endfunction

  function logic [WordW-1:0] predict_rate(logic [WordW-1:0] word);
    logic [NumW-1:0]  numer;
    logic [MultW-1:0] mult;
    logic [DenW-1:0]  denom;
    logic [PreW-1:0]  prediv;
    logic [NumW:0]    mag;
    bit               neg;
    logic [WordW-1:0] dbl;
    logic [WordW-1:0] base;
    logic [WordW-1:0] frac;
    logic [WordW-1:0] prod;
    logic [63:0]      quot;
    numer  = word[NumLo +: NumW];
    mult   = word[MultLo +: MultW];
    denom  = word[DenLo +: DenW];
    prediv = word[PreLo +: PreW];
    if (mult < MultMin) begin
      mult = MultMin;
    end
    neg  = signed_num && (numer >= NumSign);
    mag  = neg ? NumSpan - {1'b0, numer} : {1'b0, numer};
    dbl  = ref_hz << 1;
    base = dbl / (32'(prediv) + 32'd1);
    quot = (64'(base) * 64'(mag)) / (64'(denom) + 64'd1);
    frac = quot[WordW-1:0];
    prod = base * 32'(mult);
    return neg ? prod - frac : prod + frac;
  endfunction

  function void note_setting(logic [WordW-1:0] word);
    rate_q.push_back(predict_rate(word));
  endfunction

  function int pending();
    return rate_q.size();
  endfunction

  task report(string msg);
    $display("[%0t] rate mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_rate(logic [WordW-1:0] got);
    logic [WordW-1:0] want;
    if (rate_q.size() == 0) begin
      report($sformatf("output_rate %h with no item pending", got));
    end else begin
      want = rate_q.pop_front();
      if (got !== want) begin
        report($sformatf("output_rate got %h want %h", got, want));
      end
    end
  endtask
endclass

module pll_rate_decoder_unit_tb;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 30;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [WordW-1:0]     s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [WordW-1:0]     m_axis_tdata;
  logic                 cfg_wen;
  logic [CfgIndexW-1:0] cfg_index;
  logic [WordW-1:0]     cfg_data;

  rate_scoreboard sb;
  bit hold_pending;
  int send_calm;
  int recv_calm;

  pll_rate_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [WordW-1:0] make_word(int numer, int mult, int denom, int prediv);
    logic [WordW-1:0] w;
    w = '0;
    w[NumLo +: NumW]   = NumW'(numer);
    w[MultLo +: MultW] = MultW'(mult);
    w[DenLo +: DenW]   = DenW'(denom);
    w[PreLo +: PreW]   = PreW'(prediv);
    return w;
  endfunction

  function automatic logic [WordW-1:0] random_setting();
    logic [WordW-1:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w[NumLo +: NumW] = NumSign + NumW'($urandom_range(0, 3)) - NumW'(2);
      1: w[NumLo +: NumW] = $urandom_range(0, 1) ? '1 : '0;
      2: w[MultLo +: MultW] = MultW'($urandom_range(0, 5));
      3: w[DenLo +: DenW] = $urandom_range(0, 1) ? '1 : '0;
      4: w[PreLo +: PreW] = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return w;
  endfunction

  // Drive both registers, or only the reference rate, then drop the write enable.
  task configure(logic [WordW-1:0] hz, bit mode, bit with_mode);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_REFERENCE_RATE;
    cfg_data  <= hz;
    @(negedge clk);
    if (with_mode) begin
      cfg_index <= CFG_SIGNED_FRACTION_MODE;
      cfg_data  <= {{(WordW-1){1'b0}}, mode};
      @(negedge clk);
    end
    cfg_wen <= 1'b0;
    sb.set_config(hz, mode, with_mode);
  endtask

  task send_setting(logic [WordW-1:0] word, int gap);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_setting(word);
    @(negedge clk);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task push_settings(logic [WordW-1:0] words[$], bit pressure);
    if (pressure) begin
      hold_pending = 1'b1;
    end
    foreach (words[i]) begin
      send_setting(words[i], pressure ? 0 : draw_wait(send_calm));
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic random_phase(logic [WordW-1:0] hz, bit mode, int count, bit pressure);
    logic [WordW-1:0] words[$];
    configure(hz, mode, 1'b1);
    repeat (count) words.push_back(random_setting());
    push_settings(words, pressure);
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = HoldCycles;
      end
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_rate(m_axis_tdata);
      @(negedge clk);
    end
  end

  initial begin
    logic [WordW-1:0] words[$];
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_wen = 1'b0;
    cfg_index = CFG_REFERENCE_RATE;
    cfg_data = '0;
    hold_pending = 1'b0;
    send_calm = 0;
    recv_calm = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Keep the signed mode at its reset value for the first directed set.
    configure(32'd25_000_000, 1'b0, 1'b0);
    words = '{make_word(0, 0, 0, 0), make_word(0, 4, 0, 0), make_word(0, 5, 0, 0),
              make_word(0, 6, 0, 0), make_word(0, 15, 0, 0), make_word(10'h1ff, 8, 0, 0),
              make_word(10'h200, 8, 0, 0), make_word(10'h3ff, 8, 0, 0),
              make_word(10'h201, 10, 10'h3ff, 0), make_word(1, 7, 10'h3ff, 15),
              make_word(10'h3ff, 15, 10'h3ff, 15), 32'hffff_ffff, 32'hc000_c000, 32'h0};
    push_settings(words, 1'b0);

    configure(32'hffff_ffff, 1'b0, 1'b1);
    words = '{32'hffff_ffff, make_word(10'h200, 0, 0, 0), make_word(10'h3ff, 15, 0, 0),
              make_word(10'h123, 9, 7, 3)};
    push_settings(words, 1'b0);

    configure(32'h8000_0000, 1'b1, 1'b1);
    words = '{make_word(10'h3ff, 15, 0, 0), make_word(10'h155, 12, 3, 1)};
    push_settings(words, 1'b0);

    random_phase($urandom(), 1'b1, 200, 1'b0);
    random_phase(32'hffff_ffff, 1'b0, 200, 1'b0);
    random_phase(32'd26_000_000, 1'b1, 200, 1'b1);
    random_phase(32'h7fff_ffff, 1'b1, 200, 1'b0);
    random_phase(32'd0, 1'b0, 100, 1'b0);
    random_phase($urandom(), 1'b0, 200, 1'b0);
    random_phase(32'h8000_0001, 1'b1, 100, 1'b0);

    repeat (SettleCycles) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
